>>> rtl/least_loaded_rank_tracker_macros.svh
// Assertion macros for the least-loaded rank tracker RTL.
`ifndef LEAST_LOADED_RANK_TRACKER_MACROS_SVH
`define LEAST_LOADED_RANK_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define LLRT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds across reset.
`define LLRT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLRT_ASSERT(name, clk, rst, prop, msg)
`define LLRT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> rtl/llrt_pkg.sv
// Package with the widths, constants and shared types of the rank tracker.
`timescale 1ns / 1ps
package llrt_pkg;

  // Field widths.
  localparam int RANK_W    = 4;
  localparam int ELAPSED_W = 32;
  localparam int TOTAL_W   = 48;
  localparam int RANKS_W   = 5;
  localparam int CFG_IDX_W = 2;

  // Default number of ranks held.
  localparam int NUM_RANKS_DEF = 16;

  // Register reset values.
  localparam logic [RANKS_W-1:0] RANKS_RESET   = 5'd16;
  localparam logic [TOTAL_W-1:0] CEILING_RESET = 48'd99999999999000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANKS_IN_USE = 2'd0,
    CFG_CEILING      = 2'd1
  } cfg_idx_t;

  // Operations of the shared add/compare unit.
  typedef enum logic [0:0] {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } unit_op_t;

  typedef struct packed {
    unit_op_t           op;
    logic [TOTAL_W-1:0] a;
    logic [TOTAL_W-1:0] b;
  } unit_req_t;

  // carry is the add overflow, or the borrow (a < b) of a subtract.
  typedef struct packed {
    logic [TOTAL_W-1:0] res;
    logic               carry;
  } unit_rsp_t;

endpackage

>>> rtl/llrt_ifs.sv
// Channel interfaces of the rank tracker: input items, results and register writes.
`timescale 1ns / 1ps
interface llrt_item_if import llrt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RANK_W-1:0]    target_rank;
  logic [ELAPSED_W-1:0] elapsed_us;

  modport source (output valid, target_rank, elapsed_us, input ready);
  modport sink (input valid, target_rank, elapsed_us, output ready);
endinterface

interface llrt_result_if import llrt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  least_rank;
  logic [TOTAL_W-1:0] least_total;
  logic               none_found;

  modport source (output valid, least_rank, least_total, none_found, input ready);
  modport sink (input valid, least_rank, least_total, none_found, output ready);
endinterface

interface llrt_cfg_if import llrt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TOTAL_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/llrt_store.sv
// Rank total memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps
module llrt_store import llrt_pkg::*; #(
  parameter int DEPTH = NUM_RANKS_DEF,
  parameter int AW    = $clog2(NUM_RANKS_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [TOTAL_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [TOTAL_W-1:0] rdata
);

  logic [TOTAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [TOTAL_W-1:0] rdata_q;
  logic               rvld_q;

  // Data array: one write and one read each cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rvld_q <= vld[raddr];
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

>>> rtl/llrt_unit.sv
// Shared 48-bit adder used for the saturating update and for every scan compare.
`timescale 1ns / 1ps
module llrt_unit import llrt_pkg::*; (
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic [TOTAL_W:0] b_ext;
  logic [TOTAL_W:0] sum;

  // A subtract adds the inverted operand plus one; bit 48 is then the borrow.
  always_comb begin
    if (req.op == OP_SUB) begin
      b_ext = {1'b1, ~req.b};
    end else begin
      b_ext = {1'b0, req.b};
    end
    sum       = {1'b0, req.a} + b_ext + {{TOTAL_W{1'b0}}, req.op == OP_SUB};
    rsp.res   = sum[TOTAL_W-1:0];
    rsp.carry = sum[TOTAL_W];
  end

endmodule

>>> rtl/llrt_seq.sv
// Sequencer: one update step, then a rank-by-rank minimum scan through the shared unit.
`timescale 1ns / 1ps
`include "least_loaded_rank_tracker_macros.svh"
module llrt_seq import llrt_pkg::*; #(
  parameter int NUM_RANKS = NUM_RANKS_DEF,
  parameter int RW        = $clog2(NUM_RANKS_DEF),
  parameter int CW        = $clog2(NUM_RANKS_DEF + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RANK_W-1:0]    in_rank,
  input  logic [ELAPSED_W-1:0] in_elapsed,
  // Configuration
  input  logic [RANKS_W-1:0]   cfg_ranks,
  input  logic [TOTAL_W-1:0]   cfg_ceiling,
  // Memory
  output logic                 mem_we,
  output logic [RW-1:0]        mem_waddr,
  output logic [TOTAL_W-1:0]   mem_wdata,
  output logic [RW-1:0]        mem_raddr,
  input  logic [TOTAL_W-1:0]   mem_rdata,
  // Shared unit
  output unit_req_t            unit_req,
  input  unit_rsp_t            unit_rsp,
  // Result register
  input  logic                 res_free,
  output logic                 res_load,
  output logic [RANK_W-1:0]    res_rank,
  output logic [TOTAL_W-1:0]   res_total,
  output logic                 res_none
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_TAIL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t               state;
  logic [RW-1:0]        rank_addr;
  logic                 rank_ok;
  logic [ELAPSED_W-1:0] add_q;
  logic [CW-1:0]        limit;
  logic [CW-1:0]        idx;
  logic                 pend;
  logic [RW-1:0]        pend_idx;
  logic [RW-1:0]        best_rank;
  logic [TOTAL_W-1:0]   best_total;
  logic                 found;

  logic                 in_acc;
  logic [RW+RANK_W-1:0] in_rank_ext;
  logic [RW+RANK_W-1:0] best_rank_ext;
  logic [CW-1:0]        limit_in;
  logic                 take;
  logic                 better;

  // Rank index and scan length for the incoming beat.
  always_comb begin
    in_rank_ext = {{RW{1'b0}}, in_rank};
    if (int'(cfg_ranks) > NUM_RANKS) begin
      limit_in = CW'(NUM_RANKS);
    end else begin
      limit_in = CW'(cfg_ranks);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // The running bound is the ceiling until a rank qualifies, then the best total.
  always_comb begin
    unit_req.a = mem_rdata;
    if (state == S_UPD) begin
      unit_req.op = OP_ADD;
      unit_req.b  = {{(TOTAL_W - ELAPSED_W){1'b0}}, add_q};
    end else begin
      unit_req.op = OP_SUB;
      unit_req.b  = found ? best_total : cfg_ceiling;
    end
  end

  // Memory access: read the target at accept, write the saturated sum, then sweep.
  always_comb begin
    mem_we    = (state == S_UPD) && rank_ok;
    mem_waddr = rank_addr;
    mem_wdata = unit_rsp.carry ? {TOTAL_W{1'b1}} : unit_rsp.res;
    if (state == S_IDLE) begin
      mem_raddr = in_rank_ext[RW-1:0];
    end else begin
      mem_raddr = idx[RW-1:0];
    end
  end

  assign take   = ((state == S_SCAN) && pend) || (state == S_TAIL);
  assign better = take && unit_rsp.carry;

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            found <= 1'b0;
            pend  <= 1'b0;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          state <= (limit == '0) ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          pend <= 1'b1;
          if (idx + CW'(1) == limit) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          pend  <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (better) begin
        found <= 1'b1;
      end
    end
  end

  // Item and scan registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rank_addr <= in_rank_ext[RW-1:0];
      rank_ok   <= in_rank_ext < (RW + RANK_W)'(NUM_RANKS);
      add_q     <= in_elapsed;
      limit     <= limit_in;
    end
    if (state == S_UPD) begin
      idx <= '0;
    end else if (state == S_SCAN) begin
      idx      <= idx + CW'(1);
      pend_idx <= idx[RW-1:0];
    end
    if (better) begin
      best_total <= mem_rdata;
      best_rank  <= pend_idx;
    end
  end

  // Result fields; all zero with none_found set when nothing qualified.
  assign best_rank_ext = {{RANK_W{1'b0}}, best_rank};
  assign res_load      = (state == S_DONE) && res_free;
  assign res_rank      = found ? best_rank_ext[RANK_W-1:0] : '0;
  assign res_total     = found ? best_total : '0;
  assign res_none      = !found;

  `LLRT_ASSERT(a_acc_to_upd, clk, rst, in_acc |=> (state == S_UPD), "accept not followed by update")
  `LLRT_ASSERT(a_scan_in_range, clk, rst, (state == S_SCAN) |-> (idx < limit), "scan index past limit")
  `LLRT_ASSERT(a_best_below_ceil, clk, rst, (found && (state != S_IDLE)) |-> (best_total < cfg_ceiling), "best total not below ceiling")
  `LLRT_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (state == S_IDLE), "not idle after reset")

endmodule

>>> rtl/least_loaded_rank_tracker.sv
// Top level of the least-loaded rank tracker: registers, result register and wiring.
//
//   channel | dir | beat contents
//   --------+-----+----------------------------------------------
//   item    | in  | target_rank, elapsed_us
//   result  | out | least_rank, least_total, none_found
//   cfg     | in  | index (0 ranks_in_use, 1 ceiling), data
//
// An item goes through these steps in order: accept with the target read, the update,
// one read per scanned rank, the last compare and the load of the result; with no rank
// scanned the reads and the last compare are skipped.
// The result register lets the next item be accepted while a result waits; that item
// then holds in its load cycle until the waiting beat is taken.
// Reset is synchronous and clears all totals at once; register writes are always taken.
`timescale 1ns / 1ps
module least_loaded_rank_tracker import llrt_pkg::*; #(
  parameter int NUM_RANKS = NUM_RANKS_DEF
) (
  input logic         clk,
  input logic         rst,
  llrt_item_if.sink   item,
  llrt_result_if.source result,
  llrt_cfg_if.sink    cfg
);

  localparam int RW = $clog2(NUM_RANKS);
  localparam int CW = $clog2(NUM_RANKS + 1);

  logic [RANKS_W-1:0] ranks_in_use;
  logic [TOTAL_W-1:0] ceiling;

  logic               mem_we;
  logic [RW-1:0]      mem_waddr;
  logic [TOTAL_W-1:0] mem_wdata;
  logic [RW-1:0]      mem_raddr;
  logic [TOTAL_W-1:0] mem_rdata;
  unit_req_t          unit_req;
  unit_rsp_t          unit_rsp;

  logic               res_free;
  logic               res_load;
  logic [RANK_W-1:0]  res_rank;
  logic [TOTAL_W-1:0] res_total;
  logic               res_none;
  logic               out_valid;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ranks_in_use <= RANKS_RESET;
      ceiling      <= CEILING_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RANKS_IN_USE: ranks_in_use <= cfg.data[RANKS_W-1:0];
        CFG_CEILING:      ceiling      <= cfg.data;
        default:          ;
      endcase
    end
  end

  llrt_store #(
    .DEPTH (NUM_RANKS),
    .AW    (RW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  llrt_unit u_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  llrt_seq #(
    .NUM_RANKS (NUM_RANKS),
    .RW        (RW),
    .CW        (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .in_rank     (item.target_rank),
    .in_elapsed  (item.elapsed_us),
    .cfg_ranks   (ranks_in_use),
    .cfg_ceiling (ceiling),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .unit_req    (unit_req),
    .unit_rsp    (unit_rsp),
    .res_free    (res_free),
    .res_load    (res_load),
    .res_rank    (res_rank),
    .res_total   (res_total),
    .res_none    (res_none)
  );

  // Result register: free when empty or when the current beat is taken.
  assign res_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.least_rank  <= res_rank;
      result.least_total <= res_total;
      result.none_found  <= res_none;
    end
  end

  assign result.valid = out_valid;

endmodule

>>> bench/least_loaded_rank_tracker_test.sv
// Self-checking bench for the least-loaded rank tracker: directed, random and heavy traffic.
`timescale 1ns / 1ps
module least_loaded_rank_tracker_test import llrt_pkg::*;;

  localparam int NUM_RANKS    = NUM_RANKS_DEF;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 100;
  localparam int CHUNKS       = 14;
  localparam int CHUNK_ITEMS  = 100;
  localparam int HEAVY_ITEMS  = 40;

  // Register indexes the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef struct {
    logic [RANK_W-1:0]    rank;
    logic [ELAPSED_W-1:0] elapsed;
  } work_t;

  typedef struct {
    logic [RANK_W-1:0]  rank;
    logic [TOTAL_W-1:0] total;
    logic               none;
  } least_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  llrt_item_if   item();
  llrt_result_if result();
  llrt_cfg_if    cfg();

  least_loaded_rank_tracker #(.NUM_RANKS(NUM_RANKS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the block state and its registers.
  logic [TOTAL_W-1:0] load_totals [NUM_RANKS];
  logic [RANKS_W-1:0] scan_count;
  logic [TOTAL_W-1:0] ceiling_reg;

  work_t  work_backlog [$];
  least_t least_due [$];

  int sent_n = 0;
  int taken_n = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic item_fire = 1'b0;
  logic cfg_fire = 1'b0;

  // Adds the elapsed time to its rank, then finds the least loaded rank under the ceiling.
  function automatic least_t pick_least(work_t w);
    logic [TOTAL_W:0] sum;
    int lim;
    least_t best;
    best = '{rank: '0, total: '0, none: 1'b1};
    if (int'(w.rank) < NUM_RANKS) begin
      sum = {1'b0, load_totals[w.rank]} + (TOTAL_W + 1)'(w.elapsed);
      load_totals[w.rank] = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
    lim = (int'(scan_count) > NUM_RANKS) ? NUM_RANKS : int'(scan_count);
    for (int r = 0; r < lim; r++) begin
      if (load_totals[r] < ceiling_reg && (best.none || load_totals[r] < best.total)) begin
        best.rank  = RANK_W'(r);
        best.total = load_totals[r];
        best.none  = 1'b0;
      end
    end
    return best;
  endfunction

  task automatic note_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    errors++;
    if (errors <= REPORT_MAX) begin
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  // Monitor: checks result beats, predicts accepted items, tracks register writes.
  always @(posedge clk) begin
    logic item_now;
    logic result_now;
    logic cfg_now;
    least_t want;
    item_now   = !rst && item.valid === 1'b1 && item.ready === 1'b1;
    result_now = !rst && result.valid === 1'b1 && result.ready === 1'b1;
    cfg_now    = !rst && cfg.valid === 1'b1 && cfg.ready === 1'b1;
    item_fire <= item_now;
    cfg_fire  <= cfg_now;

    // Results come before the item of the same edge, which is younger.
    if (result_now) begin
      if (least_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $error("result beat with no expectation waiting");
        end
      end else begin
        want = least_due.pop_front();
        if (result.least_rank !== want.rank) begin
          note_mismatch("least_rank", 64'(want.rank), 64'(result.least_rank));
        end
        if (result.least_total !== want.total) begin
          note_mismatch("least_total", 64'(want.total), 64'(result.least_total));
        end
        if (result.none_found !== want.none) begin
          note_mismatch("none_found", 64'(want.none), 64'(result.none_found));
        end
      end
    end

    if (item_now) begin
      least_due.push_back(pick_least('{rank: item.target_rank, elapsed: item.elapsed_us}));
      taken_n++;
    end

    if (cfg_now) begin
      case (cfg.index)
        CFG_RANKS_IN_USE: scan_count = cfg.data[RANKS_W-1:0];
        CFG_CEILING:      ceiling_reg = cfg.data;
        default: ;
      endcase
    end

    // Watchdog on cycles with no beat on any channel.
    if (rst || item_now || result_now || cfg_now) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Item driver: offers the next pending beat once the current one is taken.
  always @(negedge clk) begin
    work_t w;
    if (rst) begin
      item.valid <= 1'b0;
    end else if (!item.valid || item_fire) begin
      if (work_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = work_backlog.pop_front();
        item.valid       <= 1'b1;
        item.target_rank <= w.rank;
        item.elapsed_us  <= w.elapsed;
      end else begin
        item.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_work(input logic [RANK_W-1:0] r, input logic [ELAPSED_W-1:0] e);
    work_backlog.push_back('{rank: r, elapsed: e});
    sent_n++;
  endtask

  // Waits until every item is taken and every result has come back.
  task automatic drain();
    while (taken_n != sent_n || least_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOTAL_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do begin
      @(negedge clk);
    end while (!cfg_fire);
    cfg.valid <= 1'b0;
  endtask

  // Mostly small times so that totals tie, with some large and extreme ones.
  function automatic logic [ELAPSED_W-1:0] rand_elapsed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return ELAPSED_W'($urandom_range(0, 7));
    if (pick < 70) return ELAPSED_W'($urandom_range(0, 1000));
    if (pick < 90) return $urandom;
    if (pick < 95) return ELAPSED_MAX;
    return '0;
  endfunction

  initial begin
    logic [TOTAL_W-1:0] value;
    int pick;

    item.valid       = 1'b0;
    item.target_rank = '0;
    item.elapsed_us  = '0;
    result.ready     = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = '0;
    cfg.data         = '0;
    for (int r = 0; r < NUM_RANKS; r++) begin
      load_totals[r] = '0;
    end
    scan_count  = RANKS_RESET;
    ceiling_reg = CEILING_RESET;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: all totals zero, so the tie goes to rank zero.
    queue_work(4'd0, '0);
    queue_work(4'd0, ELAPSED_MAX);
    queue_work(4'd15, 32'h8000_0000);
    queue_work(4'd1, 32'd1);
    for (int r = 2; r < 15; r++) begin
      queue_work(RANK_W'(r), 32'd1);
    end
    queue_work(4'd15, 32'h5555_5555);
    queue_work(4'd3, 32'hAAAA_AAAA);
    drain();

    // A total equal to the ceiling does not qualify.
    write_reg(CFG_CEILING, 48'd1);
    queue_work(4'd0, '0);
    drain();
    write_reg(CFG_CEILING, '0);
    queue_work(4'd5, '0);
    drain();
    write_reg(CFG_CEILING, TOTAL_MAX);

    // Scan counts of zero, one and beyond the number of ranks.
    write_reg(CFG_RANKS_IN_USE, 48'd0);
    queue_work(4'd2, 32'd7);
    drain();
    write_reg(CFG_RANKS_IN_USE, 48'd1);
    queue_work(4'd0, '0);
    drain();
    write_reg(CFG_RANKS_IN_USE, 48'd31);
    queue_work(4'd4, '0);
    drain();
    write_reg(CFG_RANKS_IN_USE, 48'd17);
    queue_work(4'd1, 32'd2);
    drain();

    // Writes to unused indexes change nothing; upper data bits of the scan count are dropped.
    write_reg(CFG_SPARE_A, '0);
    write_reg(CFG_SPARE_B, TOTAL_MAX);
    write_reg(CFG_RANKS_IN_USE, 48'hFFFF_FFFF_FFF0);
    queue_work(4'd6, '0);
    drain();

    // Random traffic in chunks, with new settings and a new pace in each.
    for (int c = 0; c < CHUNKS; c++) begin
      drain();
      pick = $urandom_range(9);
      if (pick == 0) value = '0;
      else if (pick == 1) value = TOTAL_W'($urandom_range(17, 31));
      else value = TOTAL_W'($urandom_range(1, 16));
      if ($urandom_range(3) == 0) begin
        value = TOTAL_W'({$urandom, $urandom, value[RANKS_W-1:0]});
      end
      write_reg(CFG_RANKS_IN_USE, value);

      pick = $urandom_range(9);
      if (pick == 0) value = TOTAL_MAX;
      else if (pick == 1) value = CEILING_RESET;
      else if (pick == 2) value = TOTAL_W'({$urandom, $urandom});
      else value = load_totals[$urandom_range(NUM_RANKS - 1)] + TOTAL_W'($urandom_range(0, 2));
      write_reg(CFG_CEILING, value);
      if ($urandom_range(4) == 0) begin
        write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                  TOTAL_W'({$urandom, $urandom}));
      end

      case (c % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase

      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        if ($urandom_range(2) == 0) queue_work(RANK_W'($urandom_range(0, 3)), rand_elapsed());
        else queue_work(RANK_W'($urandom_range(NUM_RANKS - 1)), rand_elapsed());
      end

      // Back pressure: results held off while the sender keeps offering.
      if (c % 4 == 0) begin
        hold_asks++;
      end
    end
    drain();

    // Heavy load: rank zero takes the largest time back to back.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_RANKS_IN_USE, 48'd1);
    write_reg(CFG_CEILING, TOTAL_MAX);
    for (int i = 0; i < HEAVY_ITEMS; i++) begin
      queue_work(4'd0, ELAPSED_MAX);
    end
    queue_work(4'd0, '0);
    drain();
    write_reg(CFG_RANKS_IN_USE, 48'd2);
    queue_work(4'd0, 32'd5);
    queue_work(4'd1, '0);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
